[rtl/d2q9vm_pkg.sv]
package d2q9vm_pkg;

    // lattice directions
    localparam int DIR_COUNT = 9;
    localparam int DIR_REST  = 0;
    localparam int DIR_E     = 1;
    localparam int DIR_N     = 2;
    localparam int DIR_W     = 3;
    localparam int DIR_S     = 4;
    localparam int DIR_NE    = 5;
    localparam int DIR_NW    = 6;
    localparam int DIR_SW    = 7;
    localparam int DIR_SE    = 8;

    // datapath widths
    localparam int DIST_W  = 16;
    localparam int RHO_W   = 20;               // sum of nine 16-bit values
    localparam int MOM_W   = 18;               // sum of three 16-bit values
    localparam int SQ_W    = 2 * MOM_W;
    localparam int MSQ_W   = SQ_W + 1;
    localparam int ROOT_W  = 35;               // isqrt of msq * 2^32
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int REMS_W  = ROOT_W + 3;
    localparam int QUO_W   = 17;               // root / rho stays below 2^17
    localparam int DREM_W  = RHO_W + QUO_W;
    localparam int SPEED_W = 17;

    // speed marker for a blocked cell, -0.05 in Q1.15
    localparam logic signed [SPEED_W-1:0] OBSTACLE_SPEED = -17'sd1638;

    typedef logic [DIR_COUNT-1:0][DIST_W-1:0] dist_arr_t;

    typedef struct packed {
        logic obstacle;
        logic zero;
    } flags_t;

endpackage

[rtl/d2q9vm_cell_if.sv]
interface d2q9vm_cell_if;
    logic        valid;
    logic        ready;
    logic [15:0] dist_rest;
    logic [15:0] dist_east;
    logic [15:0] dist_north;
    logic [15:0] dist_west;
    logic [15:0] dist_south;
    logic [15:0] dist_northeast;
    logic [15:0] dist_northwest;
    logic [15:0] dist_southwest;
    logic [15:0] dist_southeast;
    logic        is_obstacle;

    modport source (
        output valid, dist_rest, dist_east, dist_north, dist_west, dist_south,
               dist_northeast, dist_northwest, dist_southwest, dist_southeast,
               is_obstacle,
        input  ready
    );

    modport sink (
        input  valid, dist_rest, dist_east, dist_north, dist_west, dist_south,
               dist_northeast, dist_northwest, dist_southwest, dist_southeast,
               is_obstacle,
        output ready
    );
endinterface

[rtl/d2q9vm_result_if.sv]
interface d2q9vm_result_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] speed;
    logic               zero_density;

    modport source (
        output valid, speed, zero_density,
        input  ready
    );

    modport sink (
        input  valid, speed, zero_density,
        output ready
    );
endinterface

[rtl/d2q9vm_front.sv]
module d2q9vm_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  d2q9vm_pkg::dist_arr_t         dists,
    input  logic                          obstacle,
    output logic                          out_valid,
    output logic [d2q9vm_pkg::MSQ_W-1:0]  msq,
    output logic [d2q9vm_pkg::RHO_W-1:0]  rho,
    output d2q9vm_pkg::flags_t            flags
);

    logic [d2q9vm_pkg::RHO_W-1:0] rho_sum;
    logic [d2q9vm_pkg::MOM_W-1:0] px, nx, py, ny;

    logic                         va_reg, vb_reg, vc_reg, vd_reg;
    logic [d2q9vm_pkg::RHO_W-1:0] rho_a_reg, rho_b_reg, rho_c_reg, rho_d_reg;
    logic [d2q9vm_pkg::MOM_W-1:0] px_reg, nx_reg, py_reg, ny_reg;
    logic                         obs_a_reg;
    d2q9vm_pkg::flags_t           flags_b_reg, flags_c_reg, flags_d_reg;
    logic [d2q9vm_pkg::MOM_W-1:0] ax_reg, ay_reg;
    logic [d2q9vm_pkg::SQ_W-1:0]  sqx_reg, sqy_reg;
    logic [d2q9vm_pkg::MSQ_W-1:0] msq_reg;

    // density and directional sums
    always_comb
    begin
        rho_sum = '0;
        for (int k = 0; k < d2q9vm_pkg::DIR_COUNT; k++)
        begin
            rho_sum = rho_sum + d2q9vm_pkg::RHO_W'(dists[k]);
        end
        px = d2q9vm_pkg::MOM_W'(dists[d2q9vm_pkg::DIR_E])
           + d2q9vm_pkg::MOM_W'(dists[d2q9vm_pkg::DIR_NE])
           + d2q9vm_pkg::MOM_W'(dists[d2q9vm_pkg::DIR_SE]);
        nx = d2q9vm_pkg::MOM_W'(dists[d2q9vm_pkg::DIR_W])
           + d2q9vm_pkg::MOM_W'(dists[d2q9vm_pkg::DIR_NW])
           + d2q9vm_pkg::MOM_W'(dists[d2q9vm_pkg::DIR_SW]);
        py = d2q9vm_pkg::MOM_W'(dists[d2q9vm_pkg::DIR_N])
           + d2q9vm_pkg::MOM_W'(dists[d2q9vm_pkg::DIR_NE])
           + d2q9vm_pkg::MOM_W'(dists[d2q9vm_pkg::DIR_NW]);
        ny = d2q9vm_pkg::MOM_W'(dists[d2q9vm_pkg::DIR_S])
           + d2q9vm_pkg::MOM_W'(dists[d2q9vm_pkg::DIR_SW])
           + d2q9vm_pkg::MOM_W'(dists[d2q9vm_pkg::DIR_SE]);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // sums
            rho_a_reg <= rho_sum;
            px_reg    <= px;
            nx_reg    <= nx;
            py_reg    <= py;
            ny_reg    <= ny;
            obs_a_reg <= obstacle;

            // absolute momenta, zero density check
            rho_b_reg            <= rho_a_reg;
            ax_reg               <= (px_reg >= nx_reg) ? px_reg - nx_reg : nx_reg - px_reg;
            ay_reg               <= (py_reg >= ny_reg) ? py_reg - ny_reg : ny_reg - py_reg;
            flags_b_reg.obstacle <= obs_a_reg;
            flags_b_reg.zero     <= !obs_a_reg && (rho_a_reg == '0);

            // squares
            rho_c_reg   <= rho_b_reg;
            flags_c_reg <= flags_b_reg;
            sqx_reg     <= d2q9vm_pkg::SQ_W'(ax_reg) * d2q9vm_pkg::SQ_W'(ax_reg);
            sqy_reg     <= d2q9vm_pkg::SQ_W'(ay_reg) * d2q9vm_pkg::SQ_W'(ay_reg);

            // squared magnitude
            rho_d_reg   <= rho_c_reg;
            flags_d_reg <= flags_c_reg;
            msq_reg     <= d2q9vm_pkg::MSQ_W'(sqx_reg) + d2q9vm_pkg::MSQ_W'(sqy_reg);
        end
    end

    assign out_valid = vd_reg;
    assign msq       = msq_reg;
    assign rho       = rho_d_reg;
    assign flags     = flags_d_reg;

endmodule

[rtl/d2q9vm_sqrt.sv]
module d2q9vm_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [d2q9vm_pkg::MSQ_W-1:0]  msq,
    input  logic [d2q9vm_pkg::RHO_W-1:0]  rho_in,
    input  d2q9vm_pkg::flags_t            flags_in,
    output logic                          out_valid,
    output logic [d2q9vm_pkg::ROOT_W-1:0] root,
    output logic [d2q9vm_pkg::RHO_W-1:0]  rho_out,
    output d2q9vm_pkg::flags_t            flags_out
);

    localparam int N = d2q9vm_pkg::ROOT_W;

    logic                          v_reg   [N];
    logic [d2q9vm_pkg::REMS_W-1:0] r_reg   [N];
    logic [N-1:0]                  q_reg   [N];
    logic [d2q9vm_pkg::MSQ_W-1:0]  msq_reg [N];
    logic [d2q9vm_pkg::RHO_W-1:0]  rho_reg [N];
    d2q9vm_pkg::flags_t            fl_reg  [N];

    // one root bit per stage, radicand is msq * 2^32
    for (genvar j = 0; j < N; j++)
    begin : g_stage
        logic                          v_src;
        logic [d2q9vm_pkg::REMS_W-1:0] r_src;
        logic [N-1:0]                  q_src;
        logic [d2q9vm_pkg::MSQ_W-1:0]  msq_src;
        logic [d2q9vm_pkg::RHO_W-1:0]  rho_src;
        d2q9vm_pkg::flags_t            fl_src;
        logic [d2q9vm_pkg::RAD_W-1:0]  rad;
        logic [d2q9vm_pkg::REMS_W-1:0] r_sh;
        logic [d2q9vm_pkg::REMS_W-1:0] trial;
        logic                          ge;

        if (j == 0)
        begin : g_first
            assign v_src   = in_valid;
            assign r_src   = '0;
            assign q_src   = '0;
            assign msq_src = msq;
            assign rho_src = rho_in;
            assign fl_src  = flags_in;
        end
        else
        begin : g_next
            assign v_src   = v_reg[j-1];
            assign r_src   = r_reg[j-1];
            assign q_src   = q_reg[j-1];
            assign msq_src = msq_reg[j-1];
            assign rho_src = rho_reg[j-1];
            assign fl_src  = fl_reg[j-1];
        end

        assign rad   = {1'b0, msq_src, 32'b0};
        assign r_sh  = {r_src[d2q9vm_pkg::REMS_W-3:0], rad[d2q9vm_pkg::RAD_W-1-2*j -: 2]};
        assign trial = d2q9vm_pkg::REMS_W'({q_src, 2'b01});
        assign ge    = (r_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[j] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[j]   <= ge ? r_sh - trial : r_sh;
                q_reg[j]   <= {q_src[N-2:0], ge};
                msq_reg[j] <= msq_src;
                rho_reg[j] <= rho_src;
                fl_reg[j]  <= fl_src;
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign root      = q_reg[N-1];
    assign rho_out   = rho_reg[N-1];
    assign flags_out = fl_reg[N-1];

endmodule

[rtl/d2q9vm_div.sv]
module d2q9vm_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [d2q9vm_pkg::ROOT_W-1:0] root,
    input  logic [d2q9vm_pkg::RHO_W-1:0]  rho,
    input  d2q9vm_pkg::flags_t            flags_in,
    output logic                          out_valid,
    output logic [d2q9vm_pkg::QUO_W-1:0]  quo,
    output d2q9vm_pkg::flags_t            flags_out
);

    localparam int N = d2q9vm_pkg::QUO_W;

    logic                          v_reg   [N];
    logic [d2q9vm_pkg::DREM_W-1:0] rem_reg [N];
    logic [N-1:0]                  quo_reg [N];
    logic [d2q9vm_pkg::RHO_W-1:0]  rho_reg [N];
    d2q9vm_pkg::flags_t            fl_reg  [N];

    // restoring division, one quotient bit per stage, msb first
    for (genvar j = 0; j < N; j++)
    begin : g_stage
        logic                          v_src;
        logic [d2q9vm_pkg::DREM_W-1:0] rem_src;
        logic [N-1:0]                  quo_src;
        logic [d2q9vm_pkg::RHO_W-1:0]  rho_src;
        d2q9vm_pkg::flags_t            fl_src;
        logic [d2q9vm_pkg::DREM_W-1:0] dsh;
        logic                          ge;

        if (j == 0)
        begin : g_first
            assign v_src   = in_valid;
            assign rem_src = d2q9vm_pkg::DREM_W'(root);
            assign quo_src = '0;
            assign rho_src = rho;
            assign fl_src  = flags_in;
        end
        else
        begin : g_next
            assign v_src   = v_reg[j-1];
            assign rem_src = rem_reg[j-1];
            assign quo_src = quo_reg[j-1];
            assign rho_src = rho_reg[j-1];
            assign fl_src  = fl_reg[j-1];
        end

        assign dsh = d2q9vm_pkg::DREM_W'(rho_src) << (N - 1 - j);
        assign ge  = (rem_src >= dsh);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[j] <= v_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= ge ? rem_src - dsh : rem_src;
                quo_reg[j] <= {quo_src[N-2:0], ge};
                rho_reg[j] <= rho_src;
                fl_reg[j]  <= fl_src;
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign quo       = quo_reg[N-1];
    assign flags_out = fl_reg[N-1];

endmodule

[rtl/d2q9_velocity_magnitude.sv]
// d2q9 velocity magnitude: one lattice cell in, one speed out
// pipeline from input transfer to result: 4 front stages, 35 root
// stages, 17 divide stages, 1 output register; one bit per root/divide stage
// throughput: one cell per cycle; a stalled output freezes the whole pipeline
// reset: rst_n async low, clears all valid bits, pipeline comes up empty
module d2q9_velocity_magnitude (
    input  logic            clk,
    input  logic            rst_n,
    d2q9vm_cell_if.sink     cell_in,
    d2q9vm_result_if.source result_out
);

    logic                          en;
    d2q9vm_pkg::dist_arr_t         dists;

    logic                          fr_valid;
    logic [d2q9vm_pkg::MSQ_W-1:0]  fr_msq;
    logic [d2q9vm_pkg::RHO_W-1:0]  fr_rho;
    d2q9vm_pkg::flags_t            fr_flags;

    logic                          sq_valid;
    logic [d2q9vm_pkg::ROOT_W-1:0] sq_root;
    logic [d2q9vm_pkg::RHO_W-1:0]  sq_rho;
    d2q9vm_pkg::flags_t            sq_flags;

    logic                          dv_valid;
    logic [d2q9vm_pkg::QUO_W-1:0]  dv_quo;
    d2q9vm_pkg::flags_t            dv_flags;

    logic [d2q9vm_pkg::QUO_W:0]    quo_inc;
    logic signed [d2q9vm_pkg::SPEED_W-1:0] speed_next;

    logic                                  out_valid_reg;
    logic signed [d2q9vm_pkg::SPEED_W-1:0] speed_reg;
    logic                                  zero_reg;

    // pipeline advances unless the output holds an untaken result
    assign en            = !out_valid_reg || result_out.ready;
    assign cell_in.ready = en;

    // gather distributions by direction
    always_comb
    begin
        dists[d2q9vm_pkg::DIR_REST] = cell_in.dist_rest;
        dists[d2q9vm_pkg::DIR_E]    = cell_in.dist_east;
        dists[d2q9vm_pkg::DIR_N]    = cell_in.dist_north;
        dists[d2q9vm_pkg::DIR_W]    = cell_in.dist_west;
        dists[d2q9vm_pkg::DIR_S]    = cell_in.dist_south;
        dists[d2q9vm_pkg::DIR_NE]   = cell_in.dist_northeast;
        dists[d2q9vm_pkg::DIR_NW]   = cell_in.dist_northwest;
        dists[d2q9vm_pkg::DIR_SW]   = cell_in.dist_southwest;
        dists[d2q9vm_pkg::DIR_SE]   = cell_in.dist_southeast;
    end

    d2q9vm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cell_in.valid),
        .dists     (dists),
        .obstacle  (cell_in.is_obstacle),
        .out_valid (fr_valid),
        .msq       (fr_msq),
        .rho       (fr_rho),
        .flags     (fr_flags)
    );

    d2q9vm_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .msq       (fr_msq),
        .rho_in    (fr_rho),
        .flags_in  (fr_flags),
        .out_valid (sq_valid),
        .root      (sq_root),
        .rho_out   (sq_rho),
        .flags_out (sq_flags)
    );

    d2q9vm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .root      (sq_root),
        .rho       (sq_rho),
        .flags_in  (sq_flags),
        .out_valid (dv_valid),
        .quo       (dv_quo),
        .flags_out (dv_flags)
    );

    // round half up: largest q with (2q-1)*rho <= root
    assign quo_inc = {1'b0, dv_quo} + 1'b1;

    always_comb
    begin
        if (dv_flags.obstacle)
        begin
            speed_next = d2q9vm_pkg::OBSTACLE_SPEED;
        end
        else if (dv_flags.zero)
        begin
            speed_next = '0;
        end
        else
        begin
            speed_next = quo_inc[d2q9vm_pkg::QUO_W:1];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            speed_reg <= speed_next;
            zero_reg  <= dv_flags.zero;
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.speed        = speed_reg;
    assign result_out.zero_density = zero_reg;

endmodule

[sim/testbench.sv]
module testbench;
    import d2q9vm_pkg::*;

    typedef struct {
        logic [DIST_W-1:0] vals [DIR_COUNT];
        logic              obstacle;
    } cell_t;

    typedef struct {
        logic signed [SPEED_W-1:0] speed;
        logic                      zero_density;
    } speed_t;

    logic clk;
    logic rst_n;

    d2q9vm_cell_if   cell_in ();
    d2q9vm_result_if result_out ();

    d2q9_velocity_magnitude dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_in    (cell_in.sink),
        .result_out (result_out.source)
    );

    speed_t expected_speeds [$];
    int     send_idle_pct;
    int     recv_stall_pct;
    bit     hold_off;
    int     error_count;
    int     cells_sent;
    int     speeds_checked;
    int     obstacle_count;
    int     zero_count;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("timeout at %0t", $time);
        $display("testbench NOT OK");
        $finish;
    end

    // predict speed of one cell: round(32768 * |m| / rho), exact integer search
    function automatic speed_t predict_speed(cell_t c);
        speed_t           r;
        longint unsigned  rho;
        longint unsigned  px, nx, py, ny, ax, ay, msq;
        longint unsigned  q, cand, t;
        logic [127:0]     lhs, rhs;
        rho = 0;
        r.zero_density = 1'b0;
        if (c.obstacle)
        begin
            r.speed = OBSTACLE_SPEED;
            return r;
        end
        for (int k = 0; k < DIR_COUNT; k++)
            rho += c.vals[k];
        if (rho == 0)
        begin
            r.speed = '0;
            r.zero_density = 1'b1;
            return r;
        end
        px = c.vals[DIR_E] + c.vals[DIR_NE] + c.vals[DIR_SE];
        nx = c.vals[DIR_W] + c.vals[DIR_NW] + c.vals[DIR_SW];
        py = c.vals[DIR_N] + c.vals[DIR_NE] + c.vals[DIR_NW];
        ny = c.vals[DIR_S] + c.vals[DIR_SW] + c.vals[DIR_SE];
        ax = px >= nx ? px - nx : nx - px;
        ay = py >= ny ? py - ny : ny - py;
        msq = ax * ax + ay * ay;
        rhs = {64'd0, msq} << 32;
        q = 0;
        for (int b = 15; b >= 0; b--)
        begin
            cand = q | (64'd1 << b);
            t = (2 * cand - 1) * rho;
            lhs = {64'd0, t} * {64'd0, t};
            if (lhs <= rhs)
                q = cand;
        end
        r.speed = q[SPEED_W-1:0];
        return r;
    endfunction

    // offer one cell and wait for its transfer; valid stays up for the next one
    task automatic send_cell(cell_t c);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            cell_in.valid <= 1'b0;
            @(negedge clk);
        end
        cell_in.valid          <= 1'b1;
        cell_in.dist_rest      <= c.vals[DIR_REST];
        cell_in.dist_east      <= c.vals[DIR_E];
        cell_in.dist_north     <= c.vals[DIR_N];
        cell_in.dist_west      <= c.vals[DIR_W];
        cell_in.dist_south     <= c.vals[DIR_S];
        cell_in.dist_northeast <= c.vals[DIR_NE];
        cell_in.dist_northwest <= c.vals[DIR_NW];
        cell_in.dist_southwest <= c.vals[DIR_SW];
        cell_in.dist_southeast <= c.vals[DIR_SE];
        cell_in.is_obstacle    <= c.obstacle;
        do
            @(posedge clk);
        while (!cell_in.ready);
        expected_speeds.push_back(predict_speed(c));
        cells_sent++;
        if (c.obstacle)
            obstacle_count++;
        @(negedge clk);
    endtask

    // end of a burst of cells
    task automatic stop_sending();
        cell_in.valid <= 1'b0;
    endtask

    function automatic cell_t random_cell(int obstacle_pct);
        cell_t c;
        int    shape;
        shape = $urandom_range(9);
        for (int k = 0; k < DIR_COUNT; k++)
        begin
            case (shape)
                0: c.vals[k] = $urandom_range(3);
                1: c.vals[k] = $urandom_range(1) ? 16'hffff : 16'h0000;
                2: c.vals[k] = (k == 0 || $urandom_range(2) == 0) ? $urandom : 0;
                default: c.vals[k] = $urandom;
            endcase
        end
        c.obstacle = $urandom_range(99) < obstacle_pct;
        return c;
    endfunction

    // drain everything in flight, then pass the pipeline latency
    task automatic wait_drained();
        int guard;
        guard = 0;
        while (expected_speeds.size() != 0 && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (60) @(negedge clk);
    endtask

    task automatic test_directed();
        cell_t c;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        // all zero: zero density
        foreach (c.vals[k]) c.vals[k] = 0;
        c.obstacle = 0;
        send_cell(c);
        // obstacle with zero and full distributions
        c.obstacle = 1;
        send_cell(c);
        foreach (c.vals[k]) c.vals[k] = 16'hffff;
        send_cell(c);
        // all full, open: no momentum
        c.obstacle = 0;
        send_cell(c);
        // single direction, each in turn, at full and at one lsb
        for (int d = 0; d < DIR_COUNT; d++)
        begin
            foreach (c.vals[k]) c.vals[k] = 0;
            c.vals[d] = 16'hffff;
            send_cell(c);
            c.vals[d] = 16'h0001;
            send_cell(c);
        end
        // east, north and northeast at full: speed sqrt(8)/3, then with rest added
        foreach (c.vals[k]) c.vals[k] = 0;
        c.vals[DIR_NE] = 16'hffff;
        c.vals[DIR_E]  = 16'hffff;
        c.vals[DIR_N]  = 16'hffff;
        send_cell(c);
        c.vals[DIR_REST] = 16'h8000;
        send_cell(c);
        stop_sending();
        wait_drained();
    endtask

    task automatic test_random(int count, int idle, int stall, int obstacle_pct);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (count) send_cell(random_cell(obstacle_pct));
        stop_sending();
        wait_drained();
    endtask

    // long output hold-off while cells keep coming, fills the pipeline
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(negedge clk);
                hold_off = 1'b0;
            end
            begin
                repeat (150) send_cell(random_cell(10));
                stop_sending();
            end
        join
        wait_drained();
    endtask

    // output ready, random stalls
    always @(negedge clk)
    begin
        if (!rst_n || hold_off)
            result_out.ready <= 1'b0;
        else
            result_out.ready <= !(recv_stall_pct > 0 &&
                                  $urandom_range(99) < recv_stall_pct);
    end

    // check each result transfer against the oldest prediction
    always @(posedge clk)
    begin
        speed_t want;
        if (rst_n && result_out.valid && result_out.ready)
        begin
            if (expected_speeds.size() == 0)
            begin
                $display("%0t: unexpected result speed=%0d zero=%0b", $time,
                         result_out.speed, result_out.zero_density);
                error_count++;
            end
            else
            begin
                want = expected_speeds.pop_front();
                speeds_checked++;
                if (result_out.zero_density)
                    zero_count++;
                if (result_out.speed !== want.speed)
                begin
                    $display("%0t: speed expected %0d got %0d", $time,
                             want.speed, result_out.speed);
                    error_count++;
                end
                if (result_out.zero_density !== want.zero_density)
                begin
                    $display("%0t: zero_density expected %0b got %0b", $time,
                             want.zero_density, result_out.zero_density);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        error_count = 0;
        cells_sent = 0;
        speeds_checked = 0;
        obstacle_count = 0;
        zero_count = 0;
        cell_in.valid = 1'b0;
        cell_in.dist_rest = '0;
        cell_in.dist_east = '0;
        cell_in.dist_north = '0;
        cell_in.dist_west = '0;
        cell_in.dist_south = '0;
        cell_in.dist_northeast = '0;
        cell_in.dist_northwest = '0;
        cell_in.dist_southwest = '0;
        cell_in.dist_southeast = '0;
        cell_in.is_obstacle = 1'b0;
        result_out.ready = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(300, 0, 0, 10);
        test_random(250, 49, 0, 10);
        test_random(250, 0, 49, 10);
        test_random(250, 6, 6, 10);
        test_backpressure();

        if (expected_speeds.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_speeds.size());
            error_count++;
        end
        $display("cells sent %0d, results checked %0d, obstacles %0d, zero density %0d",
                 cells_sent, speeds_checked, obstacle_count, zero_count);
        $display("phases: directed, free flow, idle input, stalled output, mixed, long hold-off");
        if (error_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
